FILE: rtl/pte_pkg.sv
// Shared types, codes and arithmetic helpers of the particle table engine.
`default_nettype none

package pte_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_SPAWN = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Fuel and rate limits
  localparam logic signed [15:0] FUEL_FREE  = -16'sd1;
  localparam logic signed [15:0] FUEL_MAX   = 16'sh7fff;
  localparam logic signed [15:0] FUEL_MIN   = 16'sh8000;
  localparam logic signed [15:0] FLIP_LIMIT = 16'sd255;
  localparam logic signed [7:0]  RATE_MAX   = 8'sd127;
  localparam logic signed [7:0]  RATE_MIN   = -8'sd128;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK
  } pte_state_t;

  // One particle slot as held in the table memory
  typedef struct packed {
    logic signed [15:0] fuel;
    logic signed [7:0]  rate;
    logic signed [15:0] xpos;
    logic signed [15:0] ypos;
    logic signed [7:0]  xvel;
    logic signed [7:0]  yvel;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pte_entry_t;

  // Table memory write request
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    pte_entry_t data;
  } pte_wr_t;

  // Clamp a 17-bit signed difference into 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] res;
    if (v[16] != v[15]) begin
      res = v[16] ? FUEL_MIN : FUEL_MAX;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pte_ram.sv
// Particle table memory: one write port, one read port, registered read data.
`default_nettype none

module pte_ram #(
  parameter int DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire pte_pkg::pte_wr_t      wr,
  input  wire logic                  rd_en,
  input  wire logic [5:0]            rd_addr,
  output      pte_pkg::pte_entry_t   rd_data
);
  import pte_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pte_entry_t mem [DEPTH];
  pte_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // Read port, read data registered and valid in the cycle after the request
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/particle_table_engine_core.sv
// Top level of the particle table engine: control sequencer, slot flags, result register.
//
// Usage: items enter on the in_ channel (in_valid / in_stall), results leave on
// the out_ channel (out_valid / out_stall). An item is taken when valid is high
// and stall is low; the block raises in_stall while it works on an item.
// - Clear: frees every slot and gives no result; the block stays idle.
// - Spawn: scans the slot flags one slot per cycle from the start hint up to the
//   first free slot, or slot SLOTS-1, writes the spawn there and loads its
//   single result (last = 1), returning to idle as that result is loaded.
// - Tick: reads the table memory one slot per cycle while out_stall is low,
//   updates live slots and writes them back, and emits one result per slot,
//   slot 0 first, last = 1 on slot SLOTS-1; the block returns to idle once the
//   last result is loaded. The single read/write port pair of the table memory
//   sets one slot/cycle.
// - Unknown kind: taken and dropped.
// The result register lets the next read proceed while a result waits; when
// out_stall is high with a result waiting, the sequence pauses and that result holds steady.
// Reset (synchronous, rst_n low) empties the result register, returns to idle
// and marks every slot free with fuel -1; no clearing pass is needed since the
// fuel reset value comes from per-slot valid flags.
`default_nettype none

module particle_table_engine_core #(
  parameter int SLOTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [4:0]         in_start_slot,
  input  wire logic signed [15:0] in_init_fuel,
  input  wire logic signed [7:0]  in_burn_rate,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [7:0]  in_step_x,
  input  wire logic signed [7:0]  in_step_y,
  input  wire logic [7:0]         in_red_in,
  input  wire logic [7:0]         in_green_in,
  input  wire logic [7:0]         in_blue_in,
  // result channel
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [4:0]         out_slot,
  output      logic               out_live,
  output      logic signed [15:0] out_fuel_out,
  output      logic signed [15:0] out_pos_x,
  output      logic signed [15:0] out_pos_y,
  output      logic [7:0]         out_red_out,
  output      logic [7:0]         out_green_out,
  output      logic [7:0]         out_blue_out,
  output      logic               out_last
);
  import pte_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [IW:0]   SLOT_END  = (IW+1)'(SLOTS);

  // Control state
  pte_state_t       state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;   // fuel entry written since clear
  logic [SLOTS-1:0] live_r, live_nxt;     // fuel above zero
  logic [IW-1:0]    scan_r, scan_nxt;
  logic [IW:0]      rd_idx_r, rd_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IW-1:0]    pend_slot_r, pend_slot_nxt;

  // Spawn payload held during the scan
  pte_entry_t       hold_r;

  // Result register
  logic             out_valid_r;
  logic [4:0]       out_slot_r;
  logic             out_live_r;
  pte_entry_t       out_ent_r;
  logic             out_last_r;

  // Result load request
  logic             load;
  logic [IW-1:0]    load_slot;
  logic             load_live;
  pte_entry_t       load_ent;
  logic             load_last;

  // Memory ports
  pte_wr_t          wr;
  logic             rd_en;
  logic [5:0]       rd_addr;
  pte_entry_t       rd_data;

  logic             in_accept;
  logic             out_free;

  // Tick datapath
  logic signed [15:0] cur_fuel;
  logic               cur_live;
  logic signed [16:0] diff1, diff2;
  logic signed [15:0] fuel1;
  logic signed [7:0]  rate_flip;
  logic               flip;
  pte_entry_t         upd;

  pte_ram #(.DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Update of the slot whose read data is present
  always_comb begin
    cur_fuel  = valid_r[pend_slot_r] ? rd_data.fuel : FUEL_FREE;
    cur_live  = (cur_fuel > 16'sd0);
    diff1     = $signed({cur_fuel[15], cur_fuel}) - $signed({{9{rd_data.rate[7]}}, rd_data.rate});
    fuel1     = sat16(diff1);
    flip      = rd_data.rate[7] && (fuel1 > FLIP_LIMIT);
    rate_flip = (rd_data.rate == RATE_MIN) ? RATE_MAX : -rd_data.rate;
    diff2     = $signed({fuel1[15], fuel1}) - $signed({{9{rate_flip[7]}}, rate_flip});
    upd       = rd_data;
    upd.fuel  = cur_fuel;
    if (cur_live) begin
      upd.fuel = flip ? sat16(diff2) : fuel1;
      upd.rate = flip ? rate_flip : rd_data.rate;
      upd.xpos = rd_data.xpos + {{8{rd_data.xvel[7]}}, rd_data.xvel};
      upd.ypos = rd_data.ypos + {{8{rd_data.yvel[7]}}, rd_data.yvel};
    end
  end

  // Sequencer: next state, memory requests and result loads
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    live_nxt      = live_r;
    scan_nxt      = scan_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    wr.en         = 1'b0;
    wr.addr       = 6'(scan_r);
    wr.data       = hold_r;
    rd_en         = 1'b0;
    rd_addr       = 6'(rd_idx_r[IW-1:0]);
    load          = 1'b0;
    load_slot     = scan_r;
    load_live     = 1'b0;
    load_ent      = hold_r;
    load_last     = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_kind)
            KIND_CLEAR: begin
              valid_nxt = '0;
              live_nxt  = '0;
            end
            KIND_SPAWN: begin
              // hint past the table goes straight to the last slot
              if (32'(in_start_slot) >= 32'(SLOTS)) begin
                scan_nxt = LAST_SLOT;
              end else begin
                scan_nxt = IW'(in_start_slot);
              end
              state_nxt = ST_SCAN;
            end
            KIND_TICK: begin
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = ST_TICK;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!live_r[scan_r] || scan_r == LAST_SLOT) begin
          if (out_free) begin
            wr.en             = 1'b1;
            valid_nxt[scan_r] = 1'b1;
            live_nxt[scan_r]  = (hold_r.fuel > 16'sd0);
            load              = 1'b1;
            load_live         = (hold_r.fuel > 16'sd0);
            state_nxt         = ST_IDLE;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      ST_TICK: begin
        // consume the slot whose read is pending
        if (pend_r && out_free) begin
          wr.en                  = cur_live;
          wr.addr                = 6'(pend_slot_r);
          wr.data                = upd;
          live_nxt[pend_slot_r]  = (upd.fuel > 16'sd0);
          load                   = 1'b1;
          load_slot              = pend_slot_r;
          load_live              = (upd.fuel > 16'sd0);
          load_ent               = upd;
          load_last              = (pend_slot_r == LAST_SLOT);
          pend_nxt               = 1'b0;
          if (pend_slot_r == LAST_SLOT) begin
            state_nxt = ST_IDLE;
          end
        end
        // read the next slot when no read is pending or the pending one is consumed now
        if ((rd_idx_r < SLOT_END) && (!pend_r || out_free)) begin
          rd_en         = 1'b1;
          rd_idx_nxt    = rd_idx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_slot_nxt = rd_idx_r[IW-1:0];
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      live_r      <= '0;
      scan_r      <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      live_r      <= live_nxt;
      scan_r      <= scan_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      pend_slot_r <= pend_slot_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Spawn payload capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_r.fuel  <= in_init_fuel;
      hold_r.rate  <= in_burn_rate;
      hold_r.xpos  <= in_start_x;
      hold_r.ypos  <= in_start_y;
      hold_r.xvel  <= in_step_x;
      hold_r.yvel  <= in_step_y;
      hold_r.red   <= in_red_in;
      hold_r.green <= in_green_in;
      hold_r.blue  <= in_blue_in;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r <= 5'(load_slot);
      out_live_r <= load_live;
      out_ent_r  <= load_ent;
      out_last_r <= load_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_live      = out_live_r;
  assign out_fuel_out  = out_ent_r.fuel;
  assign out_pos_x     = out_ent_r.xpos;
  assign out_pos_y     = out_ent_r.ypos;
  assign out_red_out   = out_ent_r.red;
  assign out_green_out = out_ent_r.green;
  assign out_blue_out  = out_ent_r.blue;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/pte_checker.sv
// Port-level checks of the particle table engine and their binding to the top level.
`default_nettype none

module pte_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [4:0]         out_slot,
  input wire logic               out_live,
  input wire logic signed [15:0] out_fuel_out,
  input wire logic               out_last
);

  // Result register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_fuel_out)
      && $stable(out_last))
    else $error("stalled result changed");

  // A result that is not the last of its run means a tick is still going
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken in the middle of a tick run");

  // The live flag agrees with the reported fuel
  a_live_fuel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_live == (out_fuel_out > 16'sd0)))
    else $error("live flag disagrees with fuel");

endmodule

bind particle_table_engine_core pte_checker u_pte_checker (.*);

`default_nettype wire
